[hw/rtl/phs_pkg.sv]
// Shared types and constants for the point hash set probe unit.
`timescale 1ns / 1ps

package phs_pkg;

	localparam int KEY_W   = 12;
	localparam int COORD_W = 14;
	localparam int HASH_W  = 25;
	localparam int MODC_W  = 5;
	localparam int CFG_W   = 12;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_FULL     = 3'd1,
		ST_OUTSIDE  = 3'd2,
		ST_ABSENT   = 3'd3,
		ST_PRESENT  = 3'd4
	} status_t;

	typedef enum logic {
		REG_FIELD_ROWS = 1'b0,
		REG_FIELD_COLS = 1'b1
	} reg_index_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_MOD,
		S_READ,
		S_CHECK
	} ctl_state_t;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] x;
		logic [KEY_W-1:0] y;
	} slot_t;

	typedef struct packed {
		logic    capture;
		logic    hash;
		logic    mod_step;
		logic    load_idx;
		logic    advance;
		logic    ins_write;
		logic    clr_write;
		logic    finish;
		status_t fin_status;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic outside;
		logic table_full;
		logic mod_done;
		logic slot_valid;
		logic slot_match;
		logic last_probe;
		logic clr_last;
	} dp_stat_t;

endpackage

[hw/rtl/phs_ctrl.sv]
// Controller state machine that sequences clearing, hashing and probing.
`timescale 1ns / 1ps

module phs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  phs_pkg::dp_stat_t   stat,
	output phs_pkg::dp_cmd_t    cmd,
	output logic                busy
);

	phs_pkg::ctl_state_t state_q;
	phs_pkg::ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= phs_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.fin_status = phs_pkg::ST_INSERTED;
		busy           = (state_q != phs_pkg::S_IDLE);
		case (state_q)
			phs_pkg::S_CLEAR: begin
				cmd.clr_write = 1'b1;
				if (stat.clr_last) begin
					state_d = phs_pkg::S_IDLE;
				end
			end
			phs_pkg::S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = phs_pkg::S_HASH;
				end
			end
			phs_pkg::S_HASH: begin
				cmd.hash = 1'b1;
				if (stat.outside) begin
					cmd.finish     = 1'b1;
					cmd.fin_status = phs_pkg::ST_OUTSIDE;
					state_d        = phs_pkg::S_IDLE;
				end else if (stat.op == phs_pkg::OP_INSERT && stat.table_full) begin
					cmd.finish     = 1'b1;
					cmd.fin_status = phs_pkg::ST_FULL;
					state_d        = phs_pkg::S_IDLE;
				end else begin
					state_d = phs_pkg::S_MOD;
				end
			end
			phs_pkg::S_MOD: begin
				if (stat.mod_done) begin
					cmd.load_idx = 1'b1;
					state_d      = phs_pkg::S_READ;
				end else begin
					cmd.mod_step = 1'b1;
				end
			end
			phs_pkg::S_READ: begin
				state_d = phs_pkg::S_CHECK;
			end
			phs_pkg::S_CHECK: begin
				if (stat.op == phs_pkg::OP_INSERT) begin
					if (!stat.slot_valid) begin
						cmd.ins_write  = 1'b1;
						cmd.finish     = 1'b1;
						cmd.fin_status = phs_pkg::ST_INSERTED;
						state_d        = phs_pkg::S_IDLE;
					end else if (stat.last_probe) begin
						cmd.finish     = 1'b1;
						cmd.fin_status = phs_pkg::ST_FULL;
						state_d        = phs_pkg::S_IDLE;
					end else begin
						cmd.advance = 1'b1;
						state_d     = phs_pkg::S_READ;
					end
				end else begin
					if (!stat.slot_valid || (!stat.slot_match && stat.last_probe)) begin
						cmd.finish     = 1'b1;
						cmd.fin_status = phs_pkg::ST_ABSENT;
						state_d        = phs_pkg::S_IDLE;
					end else if (stat.slot_match) begin
						cmd.finish     = 1'b1;
						cmd.fin_status = phs_pkg::ST_PRESENT;
						state_d        = phs_pkg::S_IDLE;
					end else begin
						cmd.advance = 1'b1;
						state_d     = phs_pkg::S_READ;
					end
				end
			end
			default: begin
				state_d = phs_pkg::S_IDLE;
			end
		endcase
	end

endmodule

[hw/rtl/phs_dpath.sv]
// Datapath with configuration, hash and remainder unit, probe index and slot memory.
`timescale 1ns / 1ps

module phs_dpath #(
	parameter int TABLE_SIZE = 4096,
	parameter int PROBE_STEP = 1021
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  phs_pkg::reg_index_t               cfg_index,
	input  logic [phs_pkg::CFG_W-1:0]         cfg_data,
	input  phs_pkg::op_t                      operation,
	input  logic signed [phs_pkg::COORD_W-1:0] x_coord,
	input  logic signed [phs_pkg::COORD_W-1:0] y_coord,
	input  phs_pkg::dp_cmd_t                  cmd,
	output phs_pkg::dp_stat_t                 stat,
	output logic                              done,
	output phs_pkg::status_t                  status
);

	localparam int IDXW    = $clog2(TABLE_SIZE);
	localparam int CNTW    = $clog2(TABLE_SIZE + 1);
	localparam bit IS_POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
	localparam logic [IDXW:0]   TS_W    = (IDXW + 1)'(TABLE_SIZE);
	localparam logic [IDXW:0]   STEP_W  = (IDXW + 1)'(PROBE_STEP % TABLE_SIZE);
	localparam logic [IDXW-1:0] LAST_IX = IDXW'(TABLE_SIZE - 1);
	localparam logic [CNTW-1:0] FULL_CT = CNTW'(TABLE_SIZE);

	logic [phs_pkg::CFG_W-1:0]          rows_q;
	logic [phs_pkg::CFG_W-1:0]          cols_q;
	phs_pkg::op_t                       op_q;
	logic [phs_pkg::COORD_W-1:0]        x_q;
	logic [phs_pkg::COORD_W-1:0]        y_q;
	logic [IDXW-1:0]                    rem_q;
	logic [phs_pkg::MODC_W-1:0]         modc_q;
	logic [IDXW-1:0]                    idx_q;
	logic [IDXW-1:0]                    probe_q;
	logic [IDXW-1:0]                    clr_q;
	logic [CNTW-1:0]                    count_q;
	logic                               done_q;
	phs_pkg::status_t                   status_q;
	phs_pkg::slot_t                     rd_q;
	phs_pkg::slot_t                     mem [TABLE_SIZE];

	logic [2*phs_pkg::KEY_W-1:0]        prod;
	logic [phs_pkg::HASH_W-1:0]         hsum;
	logic [IDXW:0]                      nxt;
	logic                               x_in;
	logic                               y_in;
	logic                               mem_we;
	logic [IDXW-1:0]                    mem_wa;
	phs_pkg::slot_t                     mem_wd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= phs_pkg::CFG_W'(4095);
			cols_q <= phs_pkg::CFG_W'(4095);
		end else if (cfg_write) begin
			if (cfg_index == phs_pkg::REG_FIELD_ROWS) begin
				rows_q <= cfg_data;
			end else begin
				cols_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= operation;
			x_q  <= x_coord;
			y_q  <= y_coord;
		end
	end

	// A coordinate is in the field when it is positive and not above its bound.
	assign x_in = !x_q[phs_pkg::COORD_W-1] && (x_q != '0)
		&& (x_q[phs_pkg::COORD_W-2:0] <= {1'b0, rows_q});
	assign y_in = !y_q[phs_pkg::COORD_W-1] && (y_q != '0)
		&& (y_q[phs_pkg::COORD_W-2:0] <= {1'b0, cols_q});

	assign prod = x_q[phs_pkg::KEY_W-1:0] * cols_q;
	assign hsum = {1'b0, prod} + {{(phs_pkg::HASH_W - phs_pkg::KEY_W){1'b0}},
		y_q[phs_pkg::KEY_W-1:0]};

	generate
		if (IS_POW2) begin : g_mask
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					modc_q <= '0;
				end else if (cmd.hash) begin
					modc_q <= '0;
				end
			end
			always_ff @(posedge clk) begin
				if (cmd.hash) begin
					rem_q <= hsum[IDXW-1:0];
				end
			end
		end else begin : g_divide
			// Remainder by reciprocal multiplication; the quotient estimate is low by at most
			// one, so a single compare and subtract finishes it.
			localparam int     MOD_STEPS = 3;
			localparam int     SHIFT     = phs_pkg::HASH_W + IDXW;
			localparam int     RCP_W     = phs_pkg::HASH_W + 1;
			localparam int     QW        = phs_pkg::HASH_W + 1 - IDXW;
			localparam longint RECIP_L   = (longint'(1) << SHIFT) / longint'(TABLE_SIZE);
			localparam logic [RCP_W-1:0] RECIP = RCP_W'(RECIP_L);

			logic [phs_pkg::HASH_W-1:0]       sh_q;
			logic [QW-1:0]                    quo_q;
			logic [IDXW:0]                    rest_q;
			logic [phs_pkg::HASH_W+RCP_W-1:0] qprod;
			logic [QW+IDXW:0]                 back;
			logic [IDXW:0]                    rest_fix;

			assign qprod    = sh_q * RECIP;
			assign back     = quo_q * TS_W;
			assign rest_fix = (rest_q >= TS_W) ? (rest_q - TS_W) : rest_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					modc_q <= '0;
				end else if (cmd.hash) begin
					modc_q <= phs_pkg::MODC_W'(MOD_STEPS);
				end else if (cmd.mod_step && modc_q != '0) begin
					modc_q <= modc_q - 1'b1;
				end
			end
			always_ff @(posedge clk) begin
				if (cmd.hash) begin
					sh_q <= hsum;
				end
				quo_q  <= qprod[SHIFT +: QW];
				rest_q <= sh_q[IDXW:0] - back[IDXW:0];
				rem_q  <= rest_fix[IDXW-1:0];
			end
		end
	endgenerate

	always_comb begin
		nxt = {1'b0, idx_q} + STEP_W;
		if (nxt >= TS_W) begin
			nxt = nxt - TS_W;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_idx) begin
			idx_q   <= rem_q;
			probe_q <= '0;
		end else if (cmd.advance) begin
			idx_q   <= nxt[IDXW-1:0];
			probe_q <= probe_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			count_q <= '0;
		end else begin
			if (cmd.clr_write) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.ins_write) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_comb begin
		mem_we   = cmd.clr_write || cmd.ins_write;
		mem_wa   = cmd.clr_write ? clr_q : idx_q;
		mem_wd   = '0;
		if (!cmd.clr_write) begin
			mem_wd.valid = 1'b1;
			mem_wd.x     = x_q[phs_pkg::KEY_W-1:0];
			mem_wd.y     = y_q[phs_pkg::KEY_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= 1'b0;
			status_q <= phs_pkg::ST_INSERTED;
		end else begin
			done_q <= cmd.finish;
			if (cmd.finish) begin
				status_q <= cmd.fin_status;
			end
		end
	end

	always_comb begin
		stat.op         = op_q;
		stat.outside    = !(x_in && y_in);
		stat.table_full = (count_q == FULL_CT);
		stat.mod_done   = (modc_q == '0);
		stat.slot_valid = rd_q.valid;
		stat.slot_match = (rd_q.x == x_q[phs_pkg::KEY_W-1:0])
			&& (rd_q.y == y_q[phs_pkg::KEY_W-1:0]);
		stat.last_probe = (probe_q == LAST_IX);
		stat.clr_last   = (clr_q == LAST_IX);
	end

	assign done   = done_q;
	assign status = status_q;

endmodule

[hw/rtl/point_hash_set_probe_unit.sv]
// Flow: capture, then hash, which ends an outside-field point or an insert into a full
// table; otherwise remainder, then for each probe an address and a registered read, with
// a reciprocal remainder when TABLE_SIZE is not a power of two. One word is in work at a
// time and busy drops as the result strobes, so a new word is taken only after the last result.
// After reset the unit clears its TABLE_SIZE slots, one per cycle, and holds busy high
// meanwhile; configuration writes are taken at any time. The receiver cannot stall.
`timescale 1ns / 1ps

module point_hash_set_probe_unit #(
	parameter int TABLE_SIZE = 4096,
	parameter int PROBE_STEP = 1021
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  phs_pkg::reg_index_t                cfg_index,
	input  logic [phs_pkg::CFG_W-1:0]          cfg_data,
	input  logic                               start,
	output logic                               busy,
	input  phs_pkg::op_t                       operation,
	input  logic signed [phs_pkg::COORD_W-1:0] x_coord,
	input  logic signed [phs_pkg::COORD_W-1:0] y_coord,
	output logic                               done,
	output phs_pkg::status_t                   status
);

	phs_pkg::dp_cmd_t  cmd;
	phs_pkg::dp_stat_t stat;

	phs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	phs_dpath #(
		.TABLE_SIZE (TABLE_SIZE),
		.PROBE_STEP (PROBE_STEP)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.operation (operation),
		.x_coord   (x_coord),
		.y_coord   (y_coord),
		.cmd       (cmd),
		.stat      (stat),
		.done      (done),
		.status    (status)
	);

endmodule

[dv/point_hash_set_probe_unit_checker.sv]
// Checker for the point hash set probe unit: predicts each status word and compares it.
`timescale 1ns / 1ps

module point_hash_set_probe_unit_checker #(
	parameter int TABLE_SIZE = 4096,
	parameter int PROBE_STEP = 1021
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  phs_pkg::reg_index_t                cfg_index,
	input  logic [phs_pkg::CFG_W-1:0]          cfg_data,
	input  logic                               start,
	input  logic                               busy,
	input  phs_pkg::op_t                       operation,
	input  logic signed [phs_pkg::COORD_W-1:0] x_coord,
	input  logic signed [phs_pkg::COORD_W-1:0] y_coord,
	input  logic                               done,
	input  phs_pkg::status_t                   status,
	output int                                 mismatches,
	output int                                 pending
);
	import phs_pkg::*;

	typedef struct {
		status_t                    want;
		op_t                        op;
		logic signed [COORD_W-1:0]  x;
		logic signed [COORD_W-1:0]  y;
	} answer_t;

	slot_t            point_slots [TABLE_SIZE];
	int               stored_points;
	logic [CFG_W-1:0] rows_limit;
	logic [CFG_W-1:0] cols_limit;
	answer_t          awaited_answers [$];
	answer_t          oldest;
	answer_t          fresh;
	status_t          predicted;
	int               mismatch_count = 0;

	assign mismatches = mismatch_count;

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		mismatch_count++;
	endtask

	function automatic status_t probe_outcome(input op_t op,
			input logic signed [COORD_W-1:0] xs, input logic signed [COORD_W-1:0] ys);
		int      xi;
		int      yi;
		int      idx;
		int      n;
		logic    settled;
		status_t result;
		xi = xs;
		yi = ys;
		if (xi < 1 || yi < 1 || xi > int'(rows_limit) || yi > int'(cols_limit)) begin
			return ST_OUTSIDE;
		end
		idx = (xi * int'(cols_limit) + yi) % TABLE_SIZE;
		settled = 1'b0;
		if (op == OP_INSERT) begin
			result = ST_FULL;
			if (stored_points < TABLE_SIZE) begin
				for (n = 0; n < TABLE_SIZE && !settled; n++) begin
					if (!point_slots[idx].valid) begin
						point_slots[idx].valid = 1'b1;
						point_slots[idx].x = xi[KEY_W-1:0];
						point_slots[idx].y = yi[KEY_W-1:0];
						stored_points++;
						result = ST_INSERTED;
						settled = 1'b1;
					end else begin
						idx = (idx + PROBE_STEP) % TABLE_SIZE;
					end
				end
			end
		end else begin
			result = ST_ABSENT;
			for (n = 0; n < TABLE_SIZE && !settled; n++) begin
				if (!point_slots[idx].valid) begin
					settled = 1'b1;
				end else if (point_slots[idx].x == xi[KEY_W-1:0] &&
						point_slots[idx].y == yi[KEY_W-1:0]) begin
					result = ST_PRESENT;
					settled = 1'b1;
				end else begin
					idx = (idx + PROBE_STEP) % TABLE_SIZE;
				end
			end
		end
		return result;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (point_slots[i]) point_slots[i] = '0;
			stored_points = 0;
			rows_limit = '1;
			cols_limit = '1;
			awaited_answers.delete();
			pending <= 0;
		end else begin
			if (done) begin
				if (awaited_answers.size() == 0) begin
					report_mismatch($sformatf("status word %0d with nothing outstanding", status));
				end else begin
					oldest = awaited_answers.pop_front();
					if (status !== oldest.want) begin
						report_mismatch($sformatf("op %0d at (%0d,%0d) answered %0d, expected %0d",
							oldest.op, oldest.x, oldest.y, status, oldest.want));
					end
				end
			end
			if (start && !busy) begin
				predicted = probe_outcome(operation, x_coord, y_coord);
				fresh.want = predicted;
				fresh.op = operation;
				fresh.x = x_coord;
				fresh.y = y_coord;
				awaited_answers.insert(awaited_answers.size(), fresh);
			end
			if (cfg_write) begin
				case (cfg_index)
					REG_FIELD_ROWS: rows_limit = cfg_data;
					REG_FIELD_COLS: cols_limit = cfg_data;
					default: ;
				endcase
			end
			pending <= awaited_answers.size();
		end
	end

endmodule

[dv/point_hash_set_probe_unit_test.sv]
// Top-level test of the point hash set probe unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module point_hash_set_probe_unit_test;
	import phs_pkg::*;

	localparam int TABLE_SIZE  = 4096;
	localparam int PROBE_STEP  = 1021;
	localparam int CYCLE_LIMIT = 50_000_000;
	localparam int SEGMENTS    = 12;
	localparam int SEG_WORDS   = 54;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_write = 1'b0;
	reg_index_t                cfg_index = REG_FIELD_ROWS;
	logic [CFG_W-1:0]          cfg_data = '0;
	logic                      start = 1'b0;
	op_t                       operation = OP_INSERT;
	logic signed [COORD_W-1:0] x_coord = '0;
	logic signed [COORD_W-1:0] y_coord = '0;
	logic                      busy;
	logic                      done;
	status_t                   status;
	int                        mismatches;
	int                        pending;

	int cycles = 0;
	int sender_gap_pct = 0;
	int words_sent = 0;
	int settings_used = 0;
	int rows_now = 4095;
	int cols_now = 4095;
	int seg_rows [SEGMENTS] = '{4095, 1, 3, 0, 4095, 1, -1, 16, 7, 2048, -1, 4095};
	int seg_cols [SEGMENTS] = '{4095, 1, 5, 7, 1, 4095, -1, 16, 0, 4095, -1, 2};
	logic signed [COORD_W-1:0] recent_x [$];
	logic signed [COORD_W-1:0] recent_y [$];

	point_hash_set_probe_unit #(
		.TABLE_SIZE(TABLE_SIZE),
		.PROBE_STEP(PROBE_STEP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.operation(operation),
		.x_coord(x_coord),
		.y_coord(y_coord),
		.done(done),
		.status(status)
	);

	point_hash_set_probe_unit_checker #(
		.TABLE_SIZE(TABLE_SIZE),
		.PROBE_STEP(PROBE_STEP)
	) probe_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.operation(operation),
		.x_coord(x_coord),
		.y_coord(y_coord),
		.done(done),
		.status(status),
		.mismatches(mismatches),
		.pending(pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d words outstanding.", cycles, pending);
			$display("point_hash_set_probe_unit_test NOT OK");
			$finish;
		end
	end

	task automatic send_word(input op_t op, input int px, input int py);
		while (sender_gap_pct != 0 && $urandom_range(0, 99) < sender_gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		x_coord <= px[COORD_W-1:0];
		y_coord <= py[COORD_W-1:0];
		do @(posedge clk); while (busy);
		words_sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	task automatic set_field(input int rows, input int cols);
		drain();
		cfg_write <= 1'b1;
		cfg_index <= REG_FIELD_ROWS;
		cfg_data <= rows[CFG_W-1:0];
		@(posedge clk);
		cfg_index <= REG_FIELD_COLS;
		cfg_data <= cols[CFG_W-1:0];
		@(posedge clk);
		cfg_write <= 1'b0;
		rows_now = rows;
		cols_now = cols;
		settings_used++;
	endtask

	function automatic logic signed [COORD_W-1:0] pick_coord(input int limit);
		int v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5, 6: v = (limit == 0) ? 1 : $urandom_range(1, limit);
			7, 8:
				case ($urandom_range(0, 7))
					0: v = 0;
					1: v = 1;
					2: v = limit;
					3: v = limit + 1;
					4: v = -1;
					5: v = -8192;
					6: v = 8191;
					default: v = 4095;
				endcase
			default: v = $urandom_range(0, 16383);
		endcase
		return v[COORD_W-1:0];
	endfunction

	task automatic send_random_word();
		op_t                       op;
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		int                        k;
		op = op_t'($urandom_range(0, 1));
		if ($urandom_range(0, 9) < 3 && recent_x.size() != 0) begin
			k = $urandom_range(0, recent_x.size() - 1);
			px = recent_x[k];
			py = recent_y[k];
		end else begin
			px = pick_coord(rows_now);
			py = pick_coord(cols_now);
		end
		if (op == OP_INSERT) begin
			recent_x.insert(recent_x.size(), px);
			recent_y.insert(recent_y.size(), py);
			if (recent_x.size() > 32) begin
				void'(recent_x.pop_front());
				void'(recent_y.pop_front());
			end
		end
		send_word(op, int'(px), int'(py));
	endtask

	initial begin
		int seg;
		int rows;
		int cols;
		int px;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (busy);

		// Directed words at the reset field of 4095 by 4095, where the hash is y - x.
		send_word(OP_INSERT, 1, 1);
		send_word(OP_LOOKUP, 1, 1);
		send_word(OP_INSERT, 1, 1);
		send_word(OP_LOOKUP, 1, 1);
		send_word(OP_INSERT, 4095, 4095);
		send_word(OP_LOOKUP, 4095, 4095);
		send_word(OP_LOOKUP, 2, 2);
		send_word(OP_INSERT, 1, 2);
		send_word(OP_INSERT, 2, 3);
		send_word(OP_LOOKUP, 2, 3);
		send_word(OP_LOOKUP, 3, 4);
		send_word(OP_INSERT, 0, 5);
		send_word(OP_LOOKUP, 5, 0);
		send_word(OP_INSERT, -1, 3);
		send_word(OP_LOOKUP, -8192, 8191);
		send_word(OP_INSERT, 8191, -8192);
		send_word(OP_LOOKUP, 1, 4096);
		send_word(OP_INSERT, 4096, 1);
		// A new column count moves the home slots of points already stored.
		set_field(4095, 4094);
		send_word(OP_LOOKUP, 1, 2);
		set_field(0, 4095);
		send_word(OP_INSERT, 1, 1);
		set_field(5, 0);
		send_word(OP_LOOKUP, 1, 1);
		send_word(OP_INSERT, 5, 4095);

		for (seg = 0; seg < SEGMENTS; seg++) begin
			sender_gap_pct = (seg < 4) ? 31 : (seg < 8) ? 81 : 0;
			rows = (seg_rows[seg] < 0) ? $urandom_range(1, 4095) : seg_rows[seg];
			cols = (seg_cols[seg] < 0) ? $urandom_range(1, 4095) : seg_cols[seg];
			set_field(rows, cols);
			repeat (SEG_WORDS) send_random_word();
		end

		// Diagonal points share one home slot at this field, so the probe chain grows.
		sender_gap_pct = 0;
		set_field(4095, 4095);
		for (px = 1; px <= 16; px++)
			send_word(OP_INSERT, px, px);
		for (px = 16; px >= 1; px--)
			send_word(OP_LOOKUP, px, px);
		send_word(OP_LOOKUP, 17, 17);
		set_field(0, 63);
		send_word(OP_INSERT, 1, 1);
		drain();
		repeat (20) @(posedge clk);

		$display("Sent %0d words over %0d field settings: duplicates, probe collisions,",
			words_sent, settings_used);
		$display("out-of-field and zero-size fields, and a long chain on one home slot.");
		if (mismatches == 0 && pending == 0) begin
			$display("point_hash_set_probe_unit_test OK");
		end else begin
			$display("point_hash_set_probe_unit_test NOT OK");
		end
		$finish;
	end

endmodule
